FILE: design/rbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_pkg
// shared types, constants and helpers of the rgb 3x3 box filter
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int LINE_W    = 2 * PIX_W;
  localparam int WIN_N     = 9;
  localparam int SUM_W     = 12;

  // floor(x / 9) == (x * 3641) >> 15 for every x up to 9 * 255
  localparam int DIV9_MUL_W = 12;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;
  localparam int DIV9_SHIFT = 15;

  localparam int FIFO_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic interior;
    logic last;
  } rbf_ctl_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input int unsigned max_v);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > max_v) begin
      res = CFG_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/rbf_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_window
// line buffer memory with read-modify-write, 3x3 window, channel sums and
// divide by nine
// ----------------------------------------------------------------------------
module rbf_window #(
  parameter int DEPTH = rbf_pkg::MAX_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  rbf_pkg::rbf_ctl_t                   ctl_in,
  input  wire [$clog2(DEPTH)-1:0]             col_in,
  input  wire [rbf_pkg::PIX_W-1:0]            pix_in,
  output rbf_pkg::rbf_ctl_t                   ctl_out,
  output logic [rbf_pkg::PIX_W-1:0]           pix_out
);
  import rbf_pkg::*;

  localparam int COL_W  = $clog2(DEPTH);
  localparam int PROD_W = SUM_W + DIV9_MUL_W;

  // per column: older row in the upper half, previous row in the lower half
  logic [LINE_W-1:0] line_mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  rbf_ctl_t          s1_ctl_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [PIX_W-1:0]  s1_pix_r;

  logic              wr_vld_r;
  logic [COL_W-1:0]  wr_addr_r;
  logic [LINE_W-1:0] wr_data_r;

  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic [PIX_W-1:0]  older;
  logic [PIX_W-1:0]  old;

  logic [PIX_W-1:0]  win_r [WIN_N];

  rbf_ctl_t          s2_ctl_r;
  rbf_ctl_t          s3_ctl_r;
  logic [SUM_W-1:0]  sum_nxt [NUM_CH];
  logic [SUM_W-1:0]  sum_r [NUM_CH];
  logic [PIX_W-1:0]  center_r;
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [PIX_W-1:0]  mean;

  always_ff @(posedge clk) begin
    if (ctl_in.valid) begin
      rd_data_r <= line_mem[col_in];
    end
    if (s1_ctl_r.valid) begin
      line_mem[s1_col_r] <= line_wr;
    end
  end

  // the write of the previous cycle is not yet seen by this cycle's read data
  always_comb begin
    if (wr_vld_r && (wr_addr_r == s1_col_r)) begin
      line_rd = wr_data_r;
    end else begin
      line_rd = rd_data_r;
    end
    older   = line_rd[LINE_W-1:PIX_W];
    old     = line_rd[PIX_W-1:0];
    line_wr = {old, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_ctl_r <= ctl_in;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      wr_vld_r <= s1_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r  <= col_in;
    s1_pix_r  <= pix_in;
    wr_addr_r <= s1_col_r;
    wr_data_r <= line_wr;
    if (s1_ctl_r.valid) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= older;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= old;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_nxt[ch] = '0;
      for (int k = 0; k < WIN_N; k++) begin
        sum_nxt[ch] = sum_nxt[ch] + SUM_W'(win_r[k][ch*CH_W +: CH_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_r[ch] <= sum_nxt[ch];
    end
    center_r <= win_r[4];
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(sum_r[ch]) * PROD_W'(DIV9_MUL);
      mean[ch*CH_W +: CH_W] = prod[ch][DIV9_SHIFT +: CH_W];
    end
    pix_out = s3_ctl_r.interior ? mean : center_r;
    ctl_out = s3_ctl_r;
  end

endmodule
`default_nettype wire

FILE: design/rgb_box_filter_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_box_filter_3x3
// 3x3 mean filter over an rgb pixel stream in raster order
// ----------------------------------------------------------------------------
// One word is taken every clock while credit is left. Each pixel leaves in
// raster order, width+1 words after it came in; interior pixels carry the
// per-channel floor of the 3x3 sum over nine, border pixels pass unchanged.
// After a frame's last pixel, flush words (or further pixels, whose values
// are dropped) push out the width+1 pending results. From acceptance to the
// output queue a word passes line buffer read, window update with write-back,
// channel sums and divide by nine. The line buffer is a single memory, read
// one cycle and written the next, with forwarding for a column that is hit
// again at once (width one). It needs no clearing after reset, since every
// result depends only on pixels of its own frame. An eight-entry output queue
// with credit counting lets input continue while results wait to be taken.
// Width and height writes take effect at once and restart the frame.
module rgb_box_filter_3x3 #(
  parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [rbf_pkg::PIX_W-1:0]         in_tdata,   // in_red, in_green, in_blue
  input  wire                              in_tuser,   // kind
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [rbf_pkg::PIX_W-1:0]        out_tdata,  // out_red, out_green, out_blue
  output logic                             out_tlast,
  input  wire                              cfg_we,
  input  wire [rbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rbf_pkg::CFG_W-1:0]         cfg_data
);
  import rbf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int CMP_A  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CMP_W  = ((CMP_A > CFG_W) ? CMP_A : CFG_W) + 1;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } rbf_out_t;

  logic [CFG_W-1:0]  eff_w_r, eff_w_nxt;
  logic [CFG_W-1:0]  eff_h_r, eff_h_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic [CMP_W-1:0]  w_c, h_c;
  logic              restart;
  logic              in_frame;
  logic              in_acc;
  logic              push;
  logic              emit;
  logic              interior;
  logic              last;
  logic              in_col_wrap;
  logic              out_col_wrap;
  logic [PIX_W-1:0]  pix;
  rbf_ctl_t          ctl_in;
  rbf_ctl_t          ctl_out;
  logic [PIX_W-1:0]  pix_out;

  rbf_out_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fifo_cnt_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              fifo_wr;
  logic              drop;
  logic              out_hs;

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    restart   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          eff_w_nxt = eff_dim(cfg_data, MAX_WIDTH);
          restart   = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_nxt = eff_dim(cfg_data, MAX_HEIGHT);
          restart   = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    w_c          = CMP_W'(eff_w_r);
    h_c          = CMP_W'(eff_h_r);
    in_acc       = in_tvalid && in_tready;
    in_frame     = CMP_W'(in_row_r) < h_c;
    // a flush inside the frame is taken and ignored
    push         = in_acc && !(in_frame && (in_tuser == KIND_FLUSH));
    // nothing comes out for the first width+1 words of a frame
    emit         = !((in_row_r == '0) || ((in_row_r == ROW_W'(1)) && (in_col_r == '0)));
    interior     = (out_row_r != '0) && ((CMP_W'(out_row_r) + 1'b1) < h_c)
                   && (out_col_r != '0) && ((CMP_W'(out_col_r) + 1'b1) < w_c);
    last         = ((CMP_W'(out_row_r) + 1'b1) >= h_c) && ((CMP_W'(out_col_r) + 1'b1) >= w_c);
    in_col_wrap  = (CMP_W'(in_col_r) + 1'b1) >= w_c;
    out_col_wrap = (CMP_W'(out_col_r) + 1'b1) >= w_c;
    pix          = in_frame ? in_tdata : '0;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (push) begin
      if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end

    ctl_in.valid    = push;
    ctl_in.emit     = emit;
    ctl_in.interior = interior;
    ctl_in.last     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= eff_dim(RST_IMAGE_WIDTH, MAX_WIDTH);
      eff_h_r   <= eff_dim(RST_IMAGE_HEIGHT, MAX_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      eff_w_r   <= eff_w_nxt;
      eff_h_r   <= eff_h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  rbf_window #(
    .DEPTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_in),
    .col_in  (in_col_r),
    .pix_in  (pix),
    .ctl_out (ctl_out),
    .pix_out (pix_out)
  );

  // output queue; every word in flight holds a credit until it leaves
  always_comb begin
    fifo_wr    = ctl_out.valid && ctl_out.emit;
    drop       = ctl_out.valid && !ctl_out.emit;
    out_tvalid = fifo_cnt_r != '0;
    out_hs     = out_tvalid && out_tready;
    out_tdata  = fifo_r[rd_ptr_r].pix;
    out_tlast  = fifo_r[rd_ptr_r].last;
    in_tready  = used_r < CNT_W'(FIFO_DEPTH);
    used_nxt   = used_r + CNT_W'(push) - CNT_W'(out_hs) - CNT_W'(drop);
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_r[wr_ptr_r].pix  <= pix_out;
      fifo_r[wr_ptr_r].last <= ctl_out.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      used_r     <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_hs) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(fifo_wr) - CNT_W'(out_hs);
      used_r     <= used_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/rbf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbf_checker
// port-level checks of the rgb 3x3 box filter
// ----------------------------------------------------------------------------
module rbf_checker (
  input wire clk,
  input wire rst_n,
  input wire in_tvalid,
  input wire in_tready,
  input wire out_tvalid,
  input wire out_tready
);

  // reset leaves an empty queue and full credit
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not empty and ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // an empty queue gets a result only from a word accepted at the pipeline input
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !$past(in_tvalid && in_tready, 3) |=> !out_tvalid)
    else $error("result appeared without a word accepted in time");

endmodule

bind rgb_box_filter_3x3 rbf_checker u_rbf_checker (.*);
`default_nettype wire
